### rtl/ibcm_pkg.sv
`timescale 1ns / 1ps
package ibcm_pkg;

    // Default bag capacity in fragment ranges.
    localparam int MAX_RANGES_DEF = 32;

    localparam int CFG_IDX_W = 1;
    localparam logic [15:0] READ_LENGTH_RST = 16'd150;
    localparam logic [15:0] MIN_OVERLAP_RST = 16'd24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_READ_LENGTH = 1'b0,
        REG_MIN_OVERLAP = 1'b1
    } cfg_reg_t;

    // One input item.
    typedef struct packed {
        logic        kind;
        logic [23:0] seq_id;
        logic [30:0] range_begin;
        logic [30:0] range_end;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] contig_begin;
        logic signed [31:0] contig_end;
        logic [31:0]        contig_length;
        logic               bag_overflow;
        logic               last;
    } out_item_t;

    // One chain cell: a pseudo read key, start+2^31 high and stop low.
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
    } slot_t;

    // Control from the sequencer to the merge unit.
    typedef struct packed {
        logic active;
        logic ovf;
    } drain_ctl_t;

    // Status from the merge unit back to the sequencer.
    typedef struct packed {
        logic pop;
        logic done;
    } drain_sts_t;

endpackage

### rtl/ibcm_cell.sv
`timescale 1ns / 1ps
module ibcm_cell
    import ibcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ins,
    input  logic        shift,
    input  logic [63:0] new_key,
    input  slot_t       left_slot,
    input  logic        left_gt,
    input  slot_t       right_slot,
    output slot_t       slot,
    output logic        gt
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] key_reg;
    logic [63:0] key_next;

    // An empty cell counts as larger than any key.
    assign gt   = !valid_reg || (key_reg > new_key);
    assign slot = '{valid: valid_reg, key: key_reg};

    // Insert shifts larger keys one place up; drain moves everything one place down.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (shift)
        begin
            valid_next = right_slot.valid;
            key_next   = right_slot.key;
        end
        else if (ins)
        begin
            if (left_gt)
            begin
                valid_next = left_slot.valid;
                key_next   = left_slot.key;
            end
            else if (gt)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

### rtl/ibcm_merge.sv
`timescale 1ns / 1ps
module ibcm_merge
    import ibcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  drain_ctl_t  ctl,
    output drain_sts_t  sts,
    input  logic        head_valid,
    input  logic [63:0] head_key,
    input  logic [15:0] min_overlap,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic               first_reg, first_next;
    logic signed [33:0] cs_reg, cs_next;
    logic signed [33:0] ce_reg, ce_next;
    logic [63:0]        prev_reg, prev_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               slot_free;
    logic signed [33:0] s, e, lo, mx, ovl;
    logic               emit, emit_last;
    logic signed [33:0] span;

    assign slot_free = !out_valid_reg || out_ready;

    // Unpack the head read and measure its overlap with the open contig.
    assign s   = $signed({2'b00, head_key[63:32]}) - 34'sd2147483648;
    assign e   = $signed({2'b00, head_key[31:0]});
    assign lo  = (ce_reg < e) ? ce_reg : e;
    assign mx  = (s > cs_reg) ? s : cs_reg;
    assign ovl = lo - mx;

    // One read per cycle from the chain head unless stalled; a gap emits a contig.
    always_comb
    begin
        first_next = first_reg;
        cs_next    = cs_reg;
        ce_next    = ce_reg;
        prev_next  = prev_reg;
        emit       = 1'b0;
        emit_last  = 1'b0;
        sts        = '{pop: 1'b0, done: 1'b0};
        if (ctl.active && slot_free)
        begin
            if (head_valid)
            begin
                sts.pop = 1'b1;
                if (first_reg)
                begin
                    cs_next    = s;
                    ce_next    = e;
                    prev_next  = head_key;
                    first_next = 1'b0;
                end
                else if (head_key != prev_reg)
                begin
                    prev_next = head_key;
                    if (ovl >= $signed({18'd0, min_overlap}))
                    begin
                        if (e > ce_reg)
                            ce_next = e;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        cs_next = s;
                        ce_next = e;
                    end
                end
            end
            else if (!first_reg)
            begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                sts.done   = 1'b1;
                first_next = 1'b1;
            end
        end
    end

    // Output register keeps the result while the receiver stalls.
    assign span = ce_reg - cs_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.contig_begin = cs_reg[31:0];
            out_data_next.contig_end   = (ce_reg > 34'sd2147483647) ? 32'sh7fffffff
                                                                    : ce_reg[31:0];
            out_data_next.contig_length = span[31:0];
            out_data_next.bag_overflow  = ctl.ovf;
            out_data_next.last          = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg       <= cs_next;
        ce_reg       <= ce_next;
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/interval_bag_contig_merger.sv
`timescale 1ns / 1ps
// Interval bag contig merger.
// Input channel (in_valid/in_ready/in_data) takes sorted fragment ranges or flush items.
// Each range places two pseudo reads into a sorted chain of cells, one read per cycle,
// so the chain insert sets the rate; the next item is taken with the second read.
// A range that closes the open bag, or a flush item with a bag open, starts a drain:
// the chain shifts one read per cycle into the merge unit, which emits contigs on the
// output channel (out_valid/out_ready/out_data). After the drain the closing range
// is inserted. last marks the final contig of a bag. When the receiver stalls, the
// output register holds its item and the drain pauses; new items wait until the drain
// ends. Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready. The
// user must see that it is written only while the block is idle; the block does not
// enforce this. Reset empties the chain, closes the bag and loads read_length = 150
// and min_overlap = 24.
module interval_bag_contig_merger
    import ibcm_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int DEPTH = 2 * MAX_RANGES;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS_A = 4'b0010,
        S_INS_B = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        read_length_reg, min_overlap_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               bag_open_reg, bag_open_next;
    logic [23:0]        prev_sid_reg, prev_sid_next;
    logic [30:0]        prev_end_reg, prev_end_next;
    logic               pend_ins_reg, pend_ins_next;
    logic               ovf_reg, ovf_next;
    logic [30:0]        pend_b_reg, pend_b_next;
    logic [30:0]        pend_e_reg, pend_e_next;

    logic               accept, split, full;
    logic [63:0]        new_key;
    logic               ins;
    drain_ctl_t         dctl;
    drain_sts_t         dsts;

    slot_t              slot   [DEPTH];
    logic               gt     [DEPTH];
    slot_t              left_s [DEPTH];
    logic               left_g [DEPTH];
    slot_t              right_s[DEPTH];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_INS_B);
    assign accept    = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_length_reg <= READ_LENGTH_RST;
            min_overlap_reg <= MIN_OVERLAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_READ_LENGTH: read_length_reg <= cfg_data;
                REG_MIN_OVERLAP: min_overlap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bag boundary test against the previous range.
    assign split = (in_data.seq_id != prev_sid_reg) ||
                   (({1'b0, in_data.range_begin} + {16'd0, min_overlap_reg}) >
                    {1'b0, prev_end_reg});
    assign full  = (count_reg >= CNT_W'(MAX_RANGES));

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        bag_open_next = bag_open_reg;
        prev_sid_next = prev_sid_reg;
        prev_end_next = prev_end_reg;
        pend_ins_next = pend_ins_reg;
        ovf_next      = ovf_reg;
        pend_b_next   = pend_b_reg;
        pend_e_next   = pend_e_reg;
        case (state_reg)
            S_INS_A: state_next = S_INS_B;
            S_INS_B: state_next = S_IDLE;
            S_DRAIN:
            begin
                if (dsts.done)
                    state_next = pend_ins_reg ? S_INS_A : S_IDLE;
            end
            default: ;
        endcase
        if (accept)
        begin
            if (in_data.kind)
            begin
                pend_ins_next = 1'b0;
                ovf_next      = 1'b0;
                count_next    = '0;
                bag_open_next = 1'b0;
                state_next    = bag_open_reg ? S_DRAIN : S_IDLE;
            end
            else
            begin
                pend_ins_next = 1'b1;
                pend_b_next   = in_data.range_begin;
                pend_e_next   = in_data.range_end;
                prev_sid_next = in_data.seq_id;
                prev_end_next = in_data.range_end;
                bag_open_next = 1'b1;
                if (bag_open_reg && (split || full))
                begin
                    ovf_next   = !split;
                    count_next = CNT_W'(1);
                    state_next = S_DRAIN;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_INS_A;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            bag_open_reg <= 1'b0;
            prev_sid_reg <= '0;
            prev_end_reg <= '0;
            pend_ins_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bag_open_reg <= bag_open_next;
            prev_sid_reg <= prev_sid_next;
            prev_end_reg <= prev_end_next;
            pend_ins_reg <= pend_ins_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_b_reg <= pend_b_next;
        pend_e_reg <= pend_e_next;
    end

    // Pseudo read keys: [begin, begin+read_length) then [end-read_length, end).
    always_comb
    begin
        if (state_reg == S_INS_A)
            new_key = {1'b1, pend_b_reg, {1'b0, pend_b_reg} + {16'd0, read_length_reg}};
        else
            new_key = {{1'b1, pend_e_reg} - {16'd0, read_length_reg}, 1'b0, pend_e_reg};
    end

    assign ins  = (state_reg == S_INS_A) || (state_reg == S_INS_B);
    assign dctl = '{active: (state_reg == S_DRAIN), ovf: ovf_reg};

    // Sorted chain of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            assign left_s[i] = '{valid: 1'b0, key: '0};
            assign left_g[i] = 1'b0;
        end
        else
        begin : g_body
            assign left_s[i] = slot[i-1];
            assign left_g[i] = gt[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_s[i] = '{valid: 1'b0, key: '0};
        end
        else
        begin : g_next
            assign right_s[i] = slot[i+1];
        end

        ibcm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ins        (ins),
            .shift      (dsts.pop),
            .new_key    (new_key),
            .left_slot  (left_s[i]),
            .left_gt    (left_g[i]),
            .right_slot (right_s[i]),
            .slot       (slot[i]),
            .gt         (gt[i])
        );
    end

    // Merge unit at the chain head.
    ibcm_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (dctl),
        .sts         (dsts),
        .head_valid  (slot[0].valid),
        .head_key    (slot[0].key),
        .min_overlap (min_overlap_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

### rtl/ibcm_checker.sv
`timescale 1ns / 1ps
module ibcm_checker
    import ibcm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input in_item_t             in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_item_t            out_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [15:0]          cfg_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Length agrees with the bounds unless the end saturated.
    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.contig_end != 32'sh7fffffff) |->
        ((out_data.contig_end - out_data.contig_begin) == out_data.contig_length))
        else $error("contig length mismatch");

    // After a range is taken, in_ready drops while the chain is busy.
    a_range_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.kind |=> !in_ready)
        else $error("item taken during insert");

endmodule

bind interval_bag_contig_merger ibcm_checker u_ibcm_checker (.*);
